### sv/indexed_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define ILST_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILST_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ilst_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Field widths, operation and status codes, cell commands and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ilst_pkg;

   localparam int DATA_W         = 32;
   localparam int FUNC_W         = 3;
   localparam int POS_W          = 8;
   localparam int STATUS_W       = 2;
   localparam int INDEX_W        = 6;
   localparam int COUNT_W        = 7;
   localparam int LIST_DEPTH_DEF = 64;

   localparam logic [FUNC_W-1:0] FUNC_APPEND   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_LAST = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_AT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_DUMP     = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_cmd_type        cmd;
      logic [COUNT_W-1:0]  pos;
      logic [COUNT_W-1:0]  total;
      logic [DATA_W-1:0]   value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [INDEX_W-1:0]  index;
      logic [DATA_W-1:0]   entry_value;
      logic [COUNT_W-1:0]  entry_count;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

### sv/ilst_req_if.sv
// ----------------------------------------------------------------------------
// Indexed list engine request channel
// Valid/ready channel carrying one list operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilst_req_if import ilst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [POS_W-1:0]  position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

`default_nettype wire

### sv/ilst_rsp_if.sv
// ----------------------------------------------------------------------------
// Indexed list engine response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilst_rsp_if import ilst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic                     found;
   logic [INDEX_W-1:0]       index;
   logic signed [DATA_W-1:0] entry_value;
   logic [COUNT_W-1:0]       entry_count;
   logic                     last;

   modport source (output valid, status, found, index, entry_value, entry_count, last,
                   input ready);
   modport sink   (input valid, status, found, index, entry_value, entry_count, last,
                   output ready);
endinterface

`default_nettype wire

### sv/ilst_cell.sv
// ----------------------------------------------------------------------------
// Indexed list engine cell
// One list entry; loads the broadcast value or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_cell import ilst_pkg::*; (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [COUNT_W-1:0]  cell_idx,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]   data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CELL_APPEND: begin
            if (cell_idx == ctrl.total) data_in = ctrl.value;
         end
         CELL_INSERT: begin
            if (cell_idx > ctrl.pos) data_in = left_data;
            else if (cell_idx == ctrl.pos) data_in = ctrl.value;
         end
         CELL_DELETE: begin
            if (cell_idx >= ctrl.pos) data_in = right_data;
         end
         CELL_ROTATE: data_in = right_data;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

### sv/indexed_list_engine.sv
// Append, insert, delete, clear: result registered in the cycle after accept.
// Find and dump: one full ring rotation in ST_SCAN, then a find's final result from ST_FINAL.
// Throughput: 1 transaction per cycle for single-result operations while the output is free;
// find and dump hold off new requests until the scan ends, one cell-ring step per cycle when free.
// Output stalls pause the scan.
// Reset: clears the entry count and control state; cell contents stay undefined.
// ----------------------------------------------------------------------------
// Indexed list engine
// Bounded ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_engine_defines.svh"

module indexed_list_engine import ilst_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ilst_req_if.sink      req_if,
   ilst_rsp_if.source    rsp_if
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   // Controller states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                is_find_ff, is_find_in;
   logic [DATA_W-1:0]   key_ff, key_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                out_free;
   logic                accept;
   logic                rsp_load;
   logic                pos_neg;
   logic [COUNT_W-1:0]  pos_val;
   logic                list_full;
   logic                scan_step;
   logic                scan_last;
   logic [COUNT_W-1:0]  scan_ext;
   logic                in_list;
   logic [DATA_W-1:0]   head;
   cell_ctrl_type       ctrl;
   logic [DATA_W-1:0]   cell_data [LIST_DEPTH];

   // ---------------------------------------------------------------------------
   // Row of cells. Cell i sees i-1 on its left and i+1 on its right, closed into
   // a ring so a full rotation brings every entry back to its own cell.
   // ---------------------------------------------------------------------------
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      ilst_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_idx   (COUNT_W'(i)),
         .left_data  (cell_data[(i + LIST_DEPTH - 1) % LIST_DEPTH]),
         .right_data (cell_data[(i + 1) % LIST_DEPTH]),
         .data       (cell_data[i])
      );
   end

   // The output register frees up when empty or when its transaction leaves now.
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_if.valid && req_if.ready;

   assign pos_neg   = req_if.position[POS_W-1];
   assign pos_val   = COUNT_W'(req_if.position[POS_W-2:0]);
   assign list_full = total_ff >= COUNT_W'(LIST_DEPTH);

   // Cell 0 holds entry scan_ff after scan_ff rotations.
   assign head      = cell_data[0];
   assign scan_step = (state_ff == ST_SCAN) && out_free;
   assign scan_last = scan_ff == IDX_W'(LIST_DEPTH - 1);
   assign scan_ext  = COUNT_W'(scan_ff);
   assign in_list   = scan_ext < total_ff;

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      scan_in     = scan_ff;
      is_find_in  = is_find_ff;
      key_in      = key_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      rsp_load    = 1'b0;
      rsp_in      = '0;

      ctrl.cmd    = CELL_HOLD;
      ctrl.pos    = pos_val;
      ctrl.total  = total_ff;
      ctrl.value  = req_if.value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               rsp_in.status = STATUS_OK;
               rsp_in.last   = 1'b1;
               case (req_if.func)
                  FUNC_APPEND: begin
                     if (list_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctrl.cmd = CELL_APPEND;
                        total_in = total_ff + COUNT_W'(1);
                     end
                  end
                  FUNC_INSERT: begin
                     if (pos_neg || pos_val > total_ff) begin
                        rsp_in.status = STATUS_RANGE;
                     end else if (list_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctrl.cmd = CELL_INSERT;
                        total_in = total_ff + COUNT_W'(1);
                     end
                  end
                  FUNC_DEL_LAST: begin
                     if (total_ff == '0) rsp_in.status = STATUS_EMPTY;
                     else total_in = total_ff - COUNT_W'(1);
                  end
                  FUNC_DEL_AT: begin
                     if (pos_neg || pos_val >= total_ff) begin
                        rsp_in.status = STATUS_RANGE;
                     end else begin
                        ctrl.cmd = CELL_DELETE;
                        total_in = total_ff - COUNT_W'(1);
                     end
                  end
                  FUNC_FIND, FUNC_DUMP: begin
                     if (total_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        // Start the walk; results come from the ring head.
                        rsp_load    = 1'b0;
                        state_in    = ST_SCAN;
                        scan_in     = '0;
                        is_find_in  = req_if.func == FUNC_FIND;
                        key_in      = req_if.value;
                        pend_in     = 1'b0;
                     end
                  end
                  FUNC_CLEAR: total_in = '0;
                  default:    rsp_in.status = STATUS_OK;
               endcase
            end
         end

         ST_SCAN: begin
            if (scan_step) begin
               ctrl.cmd = CELL_ROTATE;
               scan_in  = scan_ff + IDX_W'(1);
               if (is_find_ff) begin
                  // Hold each match until the next one shows whether it was the last.
                  if (in_list && head == key_ff) begin
                     if (pend_ff) begin
                        rsp_load      = 1'b1;
                        rsp_in.found  = 1'b1;
                        rsp_in.index  = INDEX_W'(pend_idx_ff);
                     end
                     pend_in     = 1'b1;
                     pend_idx_in = scan_ff;
                  end
               end else if (in_list) begin
                  rsp_load           = 1'b1;
                  rsp_in.found       = 1'b1;
                  rsp_in.index       = INDEX_W'(scan_ff);
                  rsp_in.entry_value = head;
                  rsp_in.last        = (scan_ext + COUNT_W'(1)) == total_ff;
               end
               if (scan_last) begin
                  scan_in  = '0;
                  state_in = is_find_ff ? ST_FINAL : ST_IDLE;
               end
            end
         end

         ST_FINAL: begin
            // Flush the held match, or report no match.
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_in.found = pend_ff;
               rsp_in.index = pend_ff ? INDEX_W'(pend_idx_ff) : '0;
               rsp_in.last  = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_in.entry_count = total_in;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      is_find_ff  <= is_find_in;
      key_ff      <= key_in;
      pend_idx_ff <= pend_idx_in;
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_ff.status;
   assign rsp_if.found       = rsp_ff.found;
   assign rsp_if.index       = rsp_ff.index;
   assign rsp_if.entry_value = rsp_ff.entry_value;
   assign rsp_if.entry_count = rsp_ff.entry_count;
   assign rsp_if.last        = rsp_ff.last;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `ILST_ASSERT_NOW(a_count_bound, 1'b1, total_ff <= COUNT_W'(LIST_DEPTH), "count above depth")
   `ILST_ASSERT_NOW(a_partial_busy, rsp_if.valid && rsp_if.ready && !rsp_if.last,
                    state_ff != ST_IDLE, "non-final result while idle")
   `ILST_ASSERT_NEXT(a_scan_count, state_ff != ST_IDLE, $stable(total_ff),
                     "count changed during scan")

endmodule

`default_nettype wire
